// ----- src/assert_macros.svh -----
// Assertion macros shared by the profiler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ccp_pkg.sv -----
// Package with the shared types and constants of the CSV column profiler.
package ccp_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int VAL_W = 31;
    localparam logic [VAL_W-1:0] SAT_MAX = {VAL_W{1'b1}};

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [1:0] CT_INT    = 2'd0;
    localparam logic [1:0] CT_FLOAT  = 2'd1;
    localparam logic [1:0] CT_STRING = 2'd2;

    typedef enum logic [1:0] {
        NP_SKIP,
        NP_DIGITS,
        NP_STOPPED
    } num_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } text_item_t;

    typedef struct packed {
        logic [11:0]      column_number;
        logic [1:0]       inferred_type;
        logic [VAL_W-1:0] largest_seen;
        logic             line_finished;
        logic             column_overflow;
    } result_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] peak;
    } col_entry_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        col_entry_t       entry;
    } wr_req_t;

endpackage

// ----- src/ccp_col_store.sv -----
// Per-column type and maximum memory with fill count and write bypass.
`include "assert_macros.svh"

module ccp_col_store (
    input  logic                clk,
    input  logic                rst_n,
    input  ccp_pkg::rd_req_t    rd,
    input  ccp_pkg::wr_req_t    wr,
    output ccp_pkg::col_entry_t entry
);

    ccp_pkg::col_entry_t mem [ccp_pkg::MAX_COLUMNS];
    ccp_pkg::col_entry_t rd_data_reg;
    ccp_pkg::col_entry_t byp_reg;
    logic                hit_reg;
    logic                fresh_reg;
    logic [ccp_pkg::COL_W-1:0] fill_reg;
    logic [ccp_pkg::COL_W-1:0] fill_next;
    logic [ccp_pkg::COL_W-1:0] wr_col;

    assign wr_col = ccp_pkg::COL_W'(wr.idx);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr[ccp_pkg::IDX_W-1:0]];
            byp_reg     <= wr.entry;
        end
    end

    // Columns are first written in ascending order, so entries at or above
    // the fill count have never been written and read as reset values.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr.en && (wr_col == fill_reg))
        begin
            fill_next = fill_reg + ccp_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            hit_reg   <= 1'b0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd.en)
            begin
                hit_reg   <= wr.en && (wr_col == rd.addr);
                fresh_reg <= rd.addr < fill_reg;
            end
        end
    end

    assign entry = hit_reg ? byp_reg : (fresh_reg ? rd_data_reg : '0);

    `CHK_IMPLY(a_fill_order, wr.en, wr_col <= fill_reg, "write beyond fill count")
    `CHK_IMPLY(a_fill_bound, 1'b1, fill_reg <= ccp_pkg::COL_W'(ccp_pkg::MAX_COLUMNS), "fill count overrun")

endmodule

// ----- src/ccp_field_unit.sv -----
// Input register, line and field state, and the per-byte update logic.
`include "assert_macros.svh"

module ccp_field_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  ccp_pkg::text_item_t   text,
    input  logic                  out_free,
    output logic                  res_valid,
    output ccp_pkg::result_item_t res,
    input  ccp_pkg::col_entry_t   entry,
    output ccp_pkg::rd_req_t      rd,
    output ccp_pkg::wr_req_t      wr
);

    logic                          in_valid_reg;
    ccp_pkg::text_item_t           in_item_reg;
    logic                          quote_reg;
    logic                          quote_next;
    logic [ccp_pkg::COL_W-1:0]     col_reg;
    logic [ccp_pkg::COL_W-1:0]     col_next;
    logic [ccp_pkg::VAL_W-1:0]     span_reg;
    logic [ccp_pkg::VAL_W-1:0]     span_next;
    ccp_pkg::num_phase_t           phase_reg;
    ccp_pkg::num_phase_t           phase_next;
    logic [ccp_pkg::VAL_W-1:0]     mag_reg;
    logic [ccp_pkg::VAL_W-1:0]     mag_next;

    logic [7:0]                    b;
    logic                          last;
    logic                          col_ok;
    logic                          is_quote;
    logic                          is_dot;
    logic                          is_digit;
    logic                          is_space;
    logic                          is_sign;
    logic                          close;
    logic                          adv;
    logic [ccp_pkg::VAL_W-1:0]     span_inc;
    logic [ccp_pkg::VAL_W+3:0]     mag_prod;
    logic [ccp_pkg::VAL_W-1:0]     mag_step;
    logic [1:0]                    kind;
    logic [ccp_pkg::VAL_W-1:0]     peak;

    assign b        = in_item_reg.text_byte;
    assign last     = in_item_reg.line_end;
    assign col_ok   = col_reg < ccp_pkg::COL_W'(ccp_pkg::MAX_COLUMNS);
    assign is_quote = b == ccp_pkg::CH_QUOTE;
    assign is_dot   = b == ccp_pkg::CH_DOT;
    assign is_digit = (b >= ccp_pkg::CH_ZERO) && (b <= ccp_pkg::CH_NINE);
    assign is_space = ((b >= ccp_pkg::CH_TAB) && (b <= ccp_pkg::CH_CR)) || (b == ccp_pkg::CH_SPACE);
    assign is_sign  = (b == ccp_pkg::CH_PLUS) || (b == ccp_pkg::CH_MINUS);
    assign span_inc = (span_reg == ccp_pkg::SAT_MAX) ? ccp_pkg::SAT_MAX : span_reg + 1'b1;

    // Times ten plus the digit; for a decimal digit the low nibble is its value.
    assign mag_prod = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                    + (ccp_pkg::VAL_W + 4)'(b[3:0]);
    assign mag_step = (mag_prod > (ccp_pkg::VAL_W + 4)'(ccp_pkg::SAT_MAX))
                    ? ccp_pkg::SAT_MAX : mag_prod[ccp_pkg::VAL_W-1:0];

    // Number parse for the current field.
    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        case (phase_reg)
            ccp_pkg::NP_SKIP:
            begin
                if (!is_space)
                begin
                    if (is_sign)
                    begin
                        phase_next = ccp_pkg::NP_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = ccp_pkg::VAL_W'(b[3:0]);
                        phase_next = ccp_pkg::NP_DIGITS;
                    end
                    else
                    begin
                        phase_next = ccp_pkg::NP_STOPPED;
                    end
                end
            end
            ccp_pkg::NP_DIGITS:
            begin
                if (is_digit)
                begin
                    mag_next = mag_step;
                end
                else
                begin
                    phase_next = ccp_pkg::NP_STOPPED;
                end
            end
            ccp_pkg::NP_STOPPED:
            begin
                phase_next = ccp_pkg::NP_STOPPED;
            end
            default:
            begin
                phase_next = ccp_pkg::NP_STOPPED;
            end
        endcase

        quote_next = quote_reg ^ is_quote;
        span_next  = span_reg;
        kind       = entry.kind;
        peak       = entry.peak;

        if (is_quote)
        begin
            if (!quote_reg)
            begin
                kind      = ccp_pkg::CT_STRING;
                span_next = ccp_pkg::VAL_W'(1);
            end
            else
            begin
                span_next = span_inc;
                if (span_inc > peak)
                begin
                    peak = span_inc;
                end
            end
        end
        else if (quote_reg)
        begin
            span_next = span_inc;
        end

        if (!quote_next && is_dot && (kind == ccp_pkg::CT_INT))
        begin
            kind = ccp_pkg::CT_FLOAT;
        end

        close    = !quote_next && ((b == ccp_pkg::CH_COMMA) || last);
        col_next = col_reg;

        if (close)
        begin
            if ((kind == ccp_pkg::CT_INT) && (mag_next > peak))
            begin
                peak = mag_next;
            end
            if (col_ok)
            begin
                col_next = col_reg + ccp_pkg::COL_W'(1);
            end
            phase_next = ccp_pkg::NP_SKIP;
            mag_next   = '0;
        end

        // A line end clears the line state even when it falls inside quotes.
        if (last)
        begin
            quote_next = 1'b0;
            col_next   = '0;
            span_next  = '0;
            phase_next = ccp_pkg::NP_SKIP;
            mag_next   = '0;
        end
    end

    assign adv        = in_valid_reg && (!close || out_free);
    assign text_stall = in_valid_reg && !adv;

    assign rd.en   = text_valid && !text_stall;
    assign rd.addr = in_valid_reg ? col_next : col_reg;

    assign wr.en          = adv && col_ok && (is_quote || is_dot || close);
    assign wr.idx         = col_reg[ccp_pkg::IDX_W-1:0];
    assign wr.entry.kind  = kind;
    assign wr.entry.peak  = peak;

    assign res_valid           = adv && close;
    assign res.column_number   = 12'(col_reg);
    assign res.inferred_type   = col_ok ? kind : ccp_pkg::CT_INT;
    assign res.largest_seen    = col_ok ? peak : '0;
    assign res.line_finished   = last;
    assign res.column_overflow = !col_ok;

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            in_item_reg <= text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            quote_reg    <= 1'b0;
            col_reg      <= '0;
            span_reg     <= '0;
            phase_reg    <= ccp_pkg::NP_SKIP;
            mag_reg      <= '0;
        end
        else
        begin
            if (rd.en)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                quote_reg <= quote_next;
                col_reg   <= col_next;
                span_reg  <= span_next;
                phase_reg <= phase_next;
                mag_reg   <= mag_next;
            end
        end
    end

    `CHK_IMPLY(a_stall_needs_item, text_stall, in_valid_reg, "stall with empty input register")
    `CHK_NEXT(a_line_end_clears, adv && last, (col_reg == '0) && !quote_reg, "line state not cleared")
    `CHK_IMPLY(a_col_bound, 1'b1, col_reg <= ccp_pkg::COL_W'(ccp_pkg::MAX_COLUMNS), "column past limit")

endmodule

// ----- src/csv_column_type_profiler_top.sv -----
// Top level of the CSV column type profiler: field unit, column store, result register.
// Throughput: one byte request per cycle, sustained, with no stall from the result side.
// A field-closing byte passes the input register, then the result register; a result stall holds it.
// Each accepted byte reads its column entry; quotes, dots and in-range closes write it back.
// Reset clears all control state; the column memory needs no clearing pass, since a
// fill count marks the written columns, so requests are taken right after reset.
`include "assert_macros.svh"

module csv_column_type_profiler_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  ccp_pkg::text_item_t   text,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ccp_pkg::result_item_t result
);

    ccp_pkg::rd_req_t      rd;
    ccp_pkg::wr_req_t      wr;
    ccp_pkg::col_entry_t   entry;
    ccp_pkg::result_item_t res;
    logic                  res_valid;
    logic                  out_free;
    logic                  out_valid_reg;
    ccp_pkg::result_item_t out_item_reg;

    assign out_free = !out_valid_reg || !result_stall;

    ccp_field_unit u_field (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .entry      (entry),
        .rd         (rd),
        .wr         (wr)
    );

    ccp_col_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .wr    (wr),
        .entry (entry)
    );

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_item_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `CHK_IMPLY(a_ovf_zero, result_valid && result.column_overflow, (result.inferred_type == ccp_pkg::CT_INT) && (result.largest_seen == '0), "overflow result not zeroed")
    `CHK_IMPLY(a_no_overwrite, res_valid, out_free, "result register overwritten")

endmodule

// ----- verif/tb_csv_column_type_profiler_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the CSV column type profiler: directed lines, then random CSV with one over-wide line.
module tb_csv_column_type_profiler_top;
    import ccp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BYTES   = 850;
    localparam int WIDE_FIELDS    = MAX_COLUMNS + 5;
    localparam int REPORT_LIMIT   = 10;

    localparam result_item_t NO_CLOSE = '0;

    typedef struct {
        text_item_t   item;
        bit           pinned;
        result_item_t want;
    } text_row_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         text_valid   = 1'b0;
    logic         text_stall;
    text_item_t   text         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result;

    // Profiler state as seen from outside.
    logic [1:0]       col_kind [MAX_COLUMNS];
    logic [VAL_W-1:0] col_peak [MAX_COLUMNS];
    logic             in_quotes;
    logic [COL_W-1:0] cur_col;
    logic [VAL_W-1:0] span_len;
    num_phase_t       parse_phase;
    logic [VAL_W-1:0] magnitude;

    result_item_t pending_closes [$];
    logic [7:0]   line_bytes [$];
    result_item_t oldest_close;

    int fail_count        = 0;
    int random_bytes_sent = 0;
    int idle_cycles       = 0;
    int gap_rate          = 0;
    int stall_left        = 0;
    int stall_rate        = 0;
    int mode_left         = 0;
    bit quiet             = 1'b0;

    // Pinned rows carry the result of the field they close typed in; other closes are predicted by profile_byte.
    text_row_t directed_rows [25] = '{
        '{'{CH_ZERO + 8'd7, 1'b1}, 1'b1, '{12'd0, CT_INT, 31'd7, 1'b1, 1'b0}},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_NINE, 1'b1}, 1'b1, '{12'd0, CT_INT, SAT_MAX, 1'b1, 1'b0}},
        '{'{CH_COMMA, 1'b0}, 1'b1, '{12'd0, CT_INT, SAT_MAX, 1'b0, 1'b0}},
        '{'{CH_QUOTE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{8'hFF, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_COMMA, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_QUOTE, 1'b0}, 1'b0, NO_CLOSE},
        '{'{8'h00, 1'b1}, 1'b1, '{12'd1, CT_STRING, 31'd4, 1'b1, 1'b0}},
        '{'{CH_TAB, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_MINUS, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_DOT, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_COMMA, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_COMMA, 1'b0}, 1'b0, NO_CLOSE},
        '{'{CH_DOT, 1'b1}, 1'b1, '{12'd2, CT_FLOAT, 31'd0, 1'b1, 1'b0}},
        '{'{CH_QUOTE, 1'b1}, 1'b0, NO_CLOSE},
        '{'{CH_ZERO + 8'd3, 1'b1}, 1'b1, '{12'd0, CT_STRING, SAT_MAX, 1'b1, 1'b0}}
    };

    csv_column_type_profiler_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .text(text),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advances the column profile by one byte and returns the field close it causes, if any.
    task automatic profile_byte(input text_item_t it, output bit closes, output result_item_t r);
        logic [7:0]  b;
        logic        col_ok;
        logic        is_digit;
        logic [63:0] scaled;
        b = it.text_byte;
        col_ok = cur_col < MAX_COLUMNS;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        closes = 1'b0;
        r = NO_CLOSE;

        if (b == CH_QUOTE)
        begin
            in_quotes = !in_quotes;
            if (in_quotes)
            begin
                if (col_ok)
                    col_kind[cur_col] = CT_STRING;
                span_len = 31'd1;
            end
            else
            begin
                span_len = (span_len == SAT_MAX) ? SAT_MAX : span_len + 1'b1;
                if (col_ok && col_peak[cur_col] < span_len)
                    col_peak[cur_col] = span_len;
            end
        end
        else if (in_quotes)
        begin
            span_len = (span_len == SAT_MAX) ? SAT_MAX : span_len + 1'b1;
        end

        case (parse_phase)
            NP_SKIP:
            begin
                if (!((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE))
                begin
                    if (b == CH_PLUS || b == CH_MINUS)
                        parse_phase = NP_DIGITS;
                    else if (is_digit)
                    begin
                        magnitude = VAL_W'(b - CH_ZERO);
                        parse_phase = NP_DIGITS;
                    end
                    else
                        parse_phase = NP_STOPPED;
                end
            end
            NP_DIGITS:
            begin
                if (is_digit)
                begin
                    scaled = 64'(magnitude) * 64'd10 + 64'(b - CH_ZERO);
                    magnitude = (scaled > 64'(SAT_MAX)) ? SAT_MAX : scaled[VAL_W-1:0];
                end
                else
                    parse_phase = NP_STOPPED;
            end
            default:
            begin
            end
        endcase

        if (!in_quotes && b == CH_DOT && col_ok && col_kind[cur_col] == CT_INT)
            col_kind[cur_col] = CT_FLOAT;

        if (!in_quotes && (b == CH_COMMA || it.line_end))
        begin
            closes = 1'b1;
            r.column_number = cur_col[11:0];
            r.line_finished = it.line_end;
            if (col_ok)
            begin
                if (col_kind[cur_col] == CT_INT && magnitude > col_peak[cur_col])
                    col_peak[cur_col] = magnitude;
                r.inferred_type = col_kind[cur_col];
                r.largest_seen = col_peak[cur_col];
                cur_col = cur_col + 1'b1;
            end
            else
                r.column_overflow = 1'b1;
            parse_phase = NP_SKIP;
            magnitude = '0;
        end

        if (it.line_end)
        begin
            in_quotes = 1'b0;
            cur_col = '0;
            span_len = '0;
            parse_phase = NP_SKIP;
            magnitude = '0;
        end
    endtask

    // Presents one byte request, waits for it to be taken and records what it must produce.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit pinned,
                             input result_item_t want);
        text_item_t   it;
        bit           closes;
        result_item_t predicted;
        it.text_byte = b;
        it.line_end = last;
        if (!quiet && $urandom_range(0, 9) < gap_rate)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text <= it;
        do @(posedge clk); while (text_stall);
        profile_byte(it, closes, predicted);
        if (pinned)
            pending_closes.push_back(want);
        else if (closes)
            pending_closes.push_back(predicted);
    endtask

    task automatic send_line(input bit counted);
        foreach (line_bytes[i])
            send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, NO_CLOSE);
        if (counted)
            random_bytes_sent += line_bytes.size();
    endtask

    // Lowers valid and holds until every pending close has come out.
    task automatic hold_until_drained();
        text_valid <= 1'b0;
        do @(posedge clk); while (pending_closes.size() != 0);
    endtask

    function automatic void push_digits(input int count);
        for (int i = 0; i < count; i++)
            line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Builds one data line of mostly well-formed fields, with some noise and open quotes.
    function automatic void build_line(input int n_fields);
        int    count;
        logic [7:0] b;
        line_bytes.delete();
        for (int f = 0; f < n_fields; f++)
        begin
            if (f != 0)
                line_bytes.push_back(CH_COMMA);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    count = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
                    for (int i = 0; i < count; i++)
                        line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE
                                                                  : 8'($urandom_range(9, 13)));
                    case ($urandom_range(0, 2))
                        0: line_bytes.push_back(CH_PLUS);
                        1: line_bytes.push_back(CH_MINUS);
                        default: ;
                    endcase
                    push_digits($urandom_range(0, 7) == 0 ? $urandom_range(10, 12)
                                                          : $urandom_range(1, 5));
                    if ($urandom_range(0, 7) == 0)
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                end
                4, 5:
                begin
                    push_digits($urandom_range(0, 3));
                    line_bytes.push_back(CH_DOT);
                    push_digits($urandom_range(0, 3));
                end
                6, 7:
                begin
                    line_bytes.push_back(CH_QUOTE);
                    count = $urandom_range(0, 8);
                    for (int i = 0; i < count; i++)
                    begin
                        case ($urandom_range(0, 5))
                            0: line_bytes.push_back(CH_COMMA);
                            1: line_bytes.push_back(CH_DOT);
                            2:
                            begin
                                line_bytes.push_back(CH_QUOTE);
                                line_bytes.push_back(CH_QUOTE);
                            end
                            default:
                            begin
                                b = 8'($urandom_range(0, 255));
                                line_bytes.push_back(b == CH_QUOTE ? CH_DOT : b);
                            end
                        endcase
                    end
                    // Now and then the closing quote is missing.
                    if ($urandom_range(0, 11) != 0)
                        line_bytes.push_back(CH_QUOTE);
                end
                8:
                begin
                    count = $urandom_range(1, 4);
                    for (int i = 0; i < count; i++)
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
        if (line_bytes.size() == 0)
            line_bytes.push_back(CH_COMMA);
    endfunction

    // A line with more fields than the column store holds, mostly empty fields.
    function automatic void build_wide_line();
        line_bytes.delete();
        for (int f = 0; f < WIDE_FIELDS; f++)
        begin
            if (f != 0)
                line_bytes.push_back(CH_COMMA);
            case ($urandom_range(0, 63))
                0: push_digits($urandom_range(1, 4));
                1:
                begin
                    line_bytes.push_back(CH_QUOTE);
                    line_bytes.push_back(8'($urandom_range(0, 255)) | 8'h80);
                    line_bytes.push_back(CH_QUOTE);
                end
                2: line_bytes.push_back(CH_DOT);
                default: ;
            endcase
        end
    endfunction

    task automatic send_random_line();
        gap_rate = $urandom_range(0, 3);
        build_line($urandom_range(0, 9) == 0 ? $urandom_range(7, 30) : $urandom_range(1, 6));
        send_line(1'b1);
    endtask

    task automatic note_failure(input string what, input result_item_t want,
                                input result_item_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s: expected col %0d type %0d max %0d end %0b ovf %0b, got col %0d type %0d max %0d end %0b ovf %0b",
                     what, want.column_number, want.inferred_type, want.largest_seen,
                     want.line_finished, want.column_overflow, got.column_number,
                     got.inferred_type, got.largest_seen, got.line_finished,
                     got.column_overflow);
    endtask

    // Result side: compare each taken result with the oldest pending close, then pick the stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_closes.size() == 0)
                note_failure("result with nothing pending", NO_CLOSE, result);
            else
            begin
                oldest_close = pending_closes.pop_front();
                if (result.column_number !== oldest_close.column_number ||
                    result.inferred_type !== oldest_close.inferred_type ||
                    result.largest_seen !== oldest_close.largest_seen ||
                    result.line_finished !== oldest_close.line_finished ||
                    result.column_overflow !== oldest_close.column_overflow)
                    note_failure("result mismatch", oldest_close, result);
            end
        end

        if (mode_left == 0)
        begin
            mode_left = $urandom_range(20, 200);
            stall_rate = $urandom_range(0, 3);
        end
        else
            mode_left--;

        if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) < stall_rate)
        begin
            stall_left = $urandom_range(0, 6);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && !text_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            col_kind[i] = CT_INT;
            col_peak[i] = '0;
        end
        in_quotes = 1'b0;
        cur_col = '0;
        span_len = '0;
        parse_phase = NP_SKIP;
        magnitude = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_rate = 2;
        foreach (directed_rows[i])
            send_byte(directed_rows[i].item.text_byte, directed_rows[i].item.line_end,
                      directed_rows[i].pinned, directed_rows[i].want);
        hold_until_drained();

        while (random_bytes_sent < 500)
            send_random_line();
        hold_until_drained();

        gap_rate = 1;
        build_wide_line();
        send_line(1'b0);

        while (random_bytes_sent < 700)
            send_random_line();
        quiet = 1'b1;
        while (random_bytes_sent < RANDOM_BYTES)
            send_random_line();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_closes.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
